FILE: hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by the top level, front end, queue, back end, checker and bench.
package tcw_pkg;

	// Command codes on the item channel
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Classified operations passed from front end to back end
	localparam logic [2:0] OP_CHAR    = 3'd0;
	localparam logic [2:0] OP_NEWLINE = 3'd1;
	localparam logic [2:0] OP_READ    = 3'd2;
	localparam logic [2:0] OP_CLEAR   = 3'd3;
	localparam logic [2:0] OP_REPORT  = 3'd4; // cursor only, cell_value 0

	localparam logic [7:0] NEWLINE_CHAR    = 8'd10;
	localparam logic [7:0] BLANK_CHAR      = 8'h20;
	localparam logic [7:0] RESET_ATTRIBUTE = 8'h07;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} tcw_item_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
	} tcw_result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} tcw_op_t;

endpackage

FILE: hdl/tcw_chan_if.sv
// Valid/ready channel carrying one word of a payload type.
// No dependencies; used for the item, result and configuration ports.
interface tcw_chan_if #(parameter type T = logic [7:0]);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/text_console_writer_unit.sv
// Top level of the text console writer: front end, operation queue, back end.
// Depends on tcw_pkg, tcw_chan_if, tcw_front, tcw_queue, tcw_back (and tcw_ram).
//
// Text-mode console engine over a COLUMNS x ROWS screen of 16-bit cells
// (attribute in the high byte, character in the low byte) with a cursor.
// Each word on items gives exactly one word on results: the cell read for
// a read command (0 for other commands or an index past the screen) plus
// the cursor row and column after the command. Commands are write char
// (newline 10 moves to the next line), read cell, and clear screen. The
// attribute byte comes from the cfg channel (reset 0x07, always ready);
// write it only while nothing is in flight. A read waits on the registered
// RAM output. Clear and scroll go through the single write port of the screen
// RAM: clear blanks every cell, and a scroll (newline or wrap on the last row)
// copies the rows up, then blanks the bottom row. After reset a clearing pass
// writes blanks over the whole screen with items.ready low.
// A two-word queue lets items be accepted while the back end works or a
// result waits on results.ready.
module text_console_writer_unit import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	tcw_chan_if.sink   items,
	tcw_chan_if.source results,
	tcw_chan_if.sink   cfg
);

	logic       cfg_take;
	logic [7:0] attribute_q;
	logic       push;
	tcw_op_t    push_op;
	logic       queue_full;
	logic       pop;
	tcw_op_t    head;
	logic       head_valid;
	logic       init_busy;

	// attribute register, taken whenever the config word is valid
	assign cfg.ready = 1'b1;
	assign cfg_take  = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attribute_q <= RESET_ATTRIBUTE;
		end else if (cfg_take) begin
			attribute_q <= cfg.data;
		end
	end

	// classify incoming words
	tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
		.item_valid(items.valid),
		.item_ready(items.ready),
		.item      (items.data),
		.queue_full(queue_full),
		.init_busy (init_busy),
		.push      (push),
		.push_op   (push_op)
	);

	// decouples acceptance from execution
	tcw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (queue_full),
		.pop     (pop),
		.head    (head),
		.nonempty(head_valid)
	);

	// cursor, screen RAM and result register
	tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (head_valid),
		.op_head  (head),
		.op_pop   (pop),
		.attribute(attribute_q),
		.init_busy(init_busy),
		.res_valid(results.valid),
		.res_ready(results.ready),
		.res_data (results.data)
	);

endmodule

FILE: hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/tcw_front.sv
// Front end: accepts item words and classifies them into back-end operations.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic      item_valid,
	output logic      item_ready,
	input  tcw_item_t item,
	input  logic      queue_full,
	input  logic      init_busy,
	output logic      push,
	output tcw_op_t   push_op
);

	localparam int CELLS = COLUMNS * ROWS;

	assign item_ready = !queue_full && !init_busy;
	assign push       = item_valid && item_ready;

	always_comb begin
		push_op.char_code  = item.char_code;
		push_op.cell_index = item.cell_index;
		unique case (item.cmd)
			CMD_WRITE: begin
				push_op.op = (item.char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_CHAR;
			end
			CMD_READ: begin
				// out-of-range reads just report the cursor
				push_op.op = (32'(item.cell_index) < CELLS) ? OP_READ : OP_REPORT;
			end
			CMD_CLEAR: begin
				push_op.op = OP_CLEAR;
			end
			default: begin
				push_op.op = OP_REPORT;
			end
		endcase
	end

endmodule

FILE: hdl/tcw_queue.sv
// Short FIFO of classified operations between front end and back end.
// Depends on tcw_pkg.
module tcw_queue import tcw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  tcw_op_t push_op,
	output logic    full,
	input  logic    pop,
	output tcw_op_t head,
	output logic    nonempty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	tcw_op_t           entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

FILE: hdl/tcw_back.sv
// Back end: cursor, screen RAM, copy/fill sequencer and result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	input  tcw_op_t     op_head,
	output logic        op_pop,
	input  logic [7:0]  attribute,
	output logic        init_busy,
	output logic        res_valid,
	input  logic        res_ready,
	output tcw_result_t res_data
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_XW = (ROW_W > 5) ? ROW_W : 5;
	localparam int COL_XW = (COL_W > 7) ? COL_W : 7;

	localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ROW1_ADDR   = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'(CELLS - COLUMNS);
	localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_READ   = 2'd1;
	localparam logic [1:0] ST_SCROLL = 2'd2;
	localparam logic [1:0] ST_FILL   = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [15:0]       fill_q, fill_d;
	logic              res_pend_q, res_pend_d;
	logic              init_q, init_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic              cp_pend_s1, cp_pend_d;
	logic [ADDR_W-1:0] cp_addr_s1, cp_addr_d;
	logic              res_valid_q;
	tcw_result_t       res_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [15:0]       mem_rdata;

	logic              out_free;
	logic              load_res;
	logic              wrap;
	logic [15:0]       res_value;
	logic [ADDR_W-1:0] cur_addr;
	logic [ROW_XW-1:0] row_x;
	logic [COL_XW-1:0] col_x;

	tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign out_free  = !res_valid_q || res_ready;
	assign cur_addr  = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
	assign row_x     = ROW_XW'(row_d);
	assign col_x     = COL_XW'(col_d);
	assign init_busy = init_q;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		fill_d     = fill_q;
		res_pend_d = res_pend_q;
		init_d     = init_q;
		row_d      = row_q;
		col_d      = col_q;
		cp_pend_d  = 1'b0;
		cp_addr_d  = cp_addr_s1;
		mem_we     = 1'b0;
		mem_waddr  = cnt_q;
		mem_wdata  = fill_q;
		mem_raddr  = cnt_q;
		op_pop     = 1'b0;
		load_res   = 1'b0;
		wrap       = 1'b0;
		res_value  = 16'h0000;
		unique case (state_q)
			ST_IDLE: begin
				if (op_valid && out_free) begin
					op_pop = 1'b1;
					unique case (op_head.op)
						OP_CHAR: begin
							mem_we    = 1'b1;
							mem_waddr = cur_addr;
							mem_wdata = {attribute, op_head.char_code};
							if (col_q != LAST_COL) begin
								col_d    = col_q + 1'b1;
								load_res = 1'b1;
							end else begin
								wrap = 1'b1;
							end
						end
						OP_NEWLINE: begin
							wrap = 1'b1;
						end
						OP_READ: begin
							mem_raddr = ADDR_W'(op_head.cell_index);
							state_d   = ST_READ;
						end
						OP_CLEAR: begin
							row_d      = '0;
							col_d      = '0;
							cnt_d      = '0;
							fill_d     = {attribute, BLANK_CHAR};
							res_pend_d = 1'b1;
							state_d    = ST_FILL;
						end
						default: begin
							load_res = 1'b1;
						end
					endcase
					if (wrap) begin
						col_d = '0;
						if (row_q != LAST_ROW) begin
							row_d    = row_q + 1'b1;
							load_res = 1'b1;
						end else begin
							// scroll: copy rows up, then blank the bottom row
							cnt_d      = ROW1_ADDR;
							fill_d     = {attribute, BLANK_CHAR};
							res_pend_d = 1'b1;
							state_d    = ST_SCROLL;
						end
					end
				end
			end
			ST_READ: begin
				res_value = mem_rdata;
				load_res  = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_SCROLL: begin
				cp_pend_d = 1'b1;
				cp_addr_d = cnt_q - ROW1_ADDR;
				if (cp_pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = cp_addr_s1;
					mem_wdata = mem_rdata;
				end
				if (cnt_q == LAST_ADDR) begin
					cnt_d   = BOTTOM_ADDR;
					state_d = ST_FILL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FILL: begin
				mem_we = 1'b1;
				if (cp_pend_s1) begin
					// last copy word of a scroll goes first
					mem_waddr = cp_addr_s1;
					mem_wdata = mem_rdata;
				end else if (cnt_q == LAST_ADDR) begin
					state_d    = ST_IDLE;
					init_d     = 1'b0;
					res_pend_d = 1'b0;
					load_res   = res_pend_q;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cnt_q       <= '0;
			fill_q      <= {RESET_ATTRIBUTE, BLANK_CHAR};
			res_pend_q  <= 1'b0;
			init_q      <= 1'b1;
			row_q       <= '0;
			col_q       <= '0;
			cp_pend_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			fill_q     <= fill_d;
			res_pend_q <= res_pend_d;
			init_q     <= init_d;
			row_q      <= row_d;
			col_q      <= col_d;
			cp_pend_s1 <= cp_pend_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cp_addr_d;
		if (load_res) begin
			res_q.cell_value    <= res_value;
			res_q.cursor_row    <= row_x[4:0];
			res_q.cursor_column <= col_x[6:0];
		end
	end

endmodule

FILE: hdl/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_unit.
module tcw_checker import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input tcw_result_t out_data
);

	localparam int OUT_W = $clog2(QUEUE_DEPTH + 2) + 1;

	logic [OUT_W-1:0] pending_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + OUT_W'(in_acc) - OUT_W'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without a pending word");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= OUT_W'(QUEUE_DEPTH + 1))
		else $error("too many words in flight");

	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(out_data.cursor_row) < ROWS)
			&& (int'(out_data.cursor_column) < COLUMNS))
		else $error("cursor off screen");

endmodule

bind text_console_writer_unit tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (items.valid),
	.in_ready (items.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_data (results.data)
);

FILE: bench/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_unit: directed rows, then random console traffic.
// Needs tcw_pkg, tcw_chan_if and the unit RTL; no files, no arguments.
module text_console_writer_unit_tb;
	import tcw_pkg::*;

	localparam int COLS  = 80;
	localparam int LINES = 25;
	localparam int CELLS = COLS * LINES;

	// cmd 3 has no name in the package; the unit must treat it as a no-op
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int PHASE_WORDS  = 185;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 50;
	// The watchdog limit leaves room for a run in which every word is a scroll
	// or a clear.
	localparam int unsigned CYCLE_LIMIT = 10_000_000;

	logic clk;
	logic arst_n;

	tcw_chan_if #(.T(tcw_item_t))   item_ch ();
	tcw_chan_if #(.T(tcw_result_t)) result_ch ();
	tcw_chan_if #(.T(logic [7:0]))  cfg_ch ();

	text_console_writer_unit #(
		.COLUMNS(COLS),
		.ROWS   (LINES)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (item_ch),
		.results(result_ch),
		.cfg    (cfg_ch)
	);

	// ---------------------------------------------------------------
	// Console image kept by the bench: screen, cursor and attribute
	// ---------------------------------------------------------------
	logic [15:0] screen_img [CELLS];
	logic [4:0]  cur_row_m;
	logic [6:0]  cur_col_m;
	logic [7:0]  attr_m;

	// Expected result words, oldest first
	tcw_result_t pending_reports [$];

	int fault_count;
	int words_sent;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_img[i] = {attr_m, BLANK_CHAR};
	endfunction

	// Column 0 of the next line; on the bottom line the screen rolls up one row
	// and the new bottom row is blanked with the current attribute.
	function automatic void line_feed();
		cur_col_m = '0;
		if (int'(cur_row_m) == LINES - 1) begin
			for (int i = 0; i < CELLS - COLS; i++)
				screen_img[i] = screen_img[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				screen_img[i] = {attr_m, BLANK_CHAR};
		end else begin
			cur_row_m = cur_row_m + 5'd1;
		end
	endfunction

	// Apply one word to the image and return the result word it must produce.
	function automatic tcw_result_t console_step(input tcw_item_t w);
		tcw_result_t r;
		r.cell_value = '0;
		case (w.cmd)
			CMD_WRITE: begin
				if (w.char_code == NEWLINE_CHAR) begin
					line_feed();
				end else begin
					screen_img[int'(cur_row_m) * COLS + int'(cur_col_m)] = {attr_m, w.char_code};
					if (int'(cur_col_m) == COLS - 1)
						line_feed();
					else
						cur_col_m = cur_col_m + 7'd1;
				end
			end
			CMD_READ: begin
				if (int'(w.cell_index) < CELLS)
					r.cell_value = screen_img[int'(w.cell_index)];
			end
			CMD_CLEAR: begin
				blank_screen();
				cur_row_m = '0;
				cur_col_m = '0;
			end
			default: ;
		endcase
		r.cursor_row    = cur_row_m;
		r.cursor_column = cur_col_m;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Directed rows. Where typed is set the expected word is written out;
	// elsewhere the image supplies it. Cursor values are after the word.
	// ---------------------------------------------------------------
	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  ch;
		logic [10:0] idx;
		logic        typed;
		tcw_result_t want;
	} probe_row_t;

	probe_row_t boot_rows [25] = '{
		// fresh screen: corners, one past the end, all-ones index
		'{CMD_READ,   8'h00, 11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0}},
		'{CMD_READ,   8'h00, 11'd1999, 1'b1, '{16'h0720, 5'd0, 7'd0}},
		'{CMD_READ,   8'h00, 11'd2000, 1'b1, '{16'h0000, 5'd0, 7'd0}},
		'{CMD_READ,   8'hFF, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
		// unused command changes nothing
		'{CMD_UNUSED, 8'hFF, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
		// char 0 and char 0xFF are stored as is
		'{CMD_WRITE,  8'h00, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd1}},
		'{CMD_WRITE,  8'hFF, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd2}},
		'{CMD_READ,   8'h00, 11'd0,    1'b1, '{16'h0700, 5'd0, 7'd2}},
		'{CMD_READ,   8'h00, 11'd1,    1'b1, '{16'h07FF, 5'd0, 7'd2}},
		'{CMD_WRITE,  8'h41, 11'd0,    1'b0, '{16'h0000, 5'd0, 7'd0}},
		// newline stores nothing, index ignored
		'{CMD_WRITE,  8'h0A, 11'd2047, 1'b1, '{16'h0000, 5'd1, 7'd0}},
		'{CMD_WRITE,  8'h7F, 11'd0,    1'b0, '{16'h0000, 5'd0, 7'd0}},
		'{CMD_READ,   8'h00, 11'd80,   1'b1, '{16'h077F, 5'd1, 7'd1}},
		'{CMD_READ,   8'h00, 11'd2,    1'b1, '{16'h0741, 5'd1, 7'd1}},
		'{CMD_WRITE,  8'h0A, 11'd0,    1'b0, '{16'h0000, 5'd0, 7'd0}},
		// clear blanks everything and homes the cursor
		'{CMD_CLEAR,  8'hFF, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
		'{CMD_READ,   8'h00, 11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0}},
		'{CMD_READ,   8'h00, 11'd80,   1'b1, '{16'h0720, 5'd0, 7'd0}},
		'{CMD_WRITE,  8'h80, 11'd0,    1'b0, '{16'h0000, 5'd0, 7'd0}},
		// newline code on an unused command is still a no-op
		'{CMD_UNUSED, 8'h0A, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd1}},
		'{CMD_READ,   8'h00, 11'd1365, 1'b1, '{16'h0720, 5'd0, 7'd1}},
		'{CMD_READ,   8'h00, 11'd682,  1'b1, '{16'h0720, 5'd0, 7'd1}},
		'{CMD_WRITE,  8'h55, 11'd1365, 1'b0, '{16'h0000, 5'd0, 7'd0}},
		'{CMD_WRITE,  8'hAA, 11'd682,  1'b0, '{16'h0000, 5'd0, 7'd0}},
		'{CMD_READ,   8'h00, 11'd1,    1'b0, '{16'h0000, 5'd0, 7'd0}}
	};

	// ---------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Item side. Called at a rising edge; returns at the edge where the
	// word was taken. valid stays high into the next word unless an idle
	// cycle is drawn, so it never gets two assignments in one step.
	// ---------------------------------------------------------------
	task automatic send_word(input tcw_item_t w, input logic typed, input tcw_result_t want);
		tcw_result_t predicted;
		while (int'($urandom_range(0, 99)) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		predicted = console_step(w);
		pending_reports.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	// One random stretch of console traffic. Mostly text runs and line feeds so
	// the cursor reaches the bottom line and scrolls; reads lean on the current
	// row; the rest is clears and raw noise.
	task automatic send_console_burst();
		tcw_item_t w;
		int kind;
		int n;
		int pick;
		kind = int'($urandom_range(0, 99));
		w.cmd        = CMD_WRITE;
		w.char_code  = 8'($urandom_range(0, 255));
		w.cell_index = 11'($urandom_range(0, 2047));
		if (kind < 45) begin
			n = int'($urandom_range(1, 40));
			repeat (n) begin
				w.char_code  = 8'($urandom_range(0, 255));
				w.cell_index = 11'($urandom_range(0, 2047));
				send_word(w, 1'b0, '0);
			end
			if ($urandom_range(0, 9) < 7) begin
				w.char_code = NEWLINE_CHAR;
				send_word(w, 1'b0, '0);
			end
		end else if (kind < 75) begin
			n = int'($urandom_range(1, 8));
			w.cmd = CMD_READ;
			repeat (n) begin
				pick = int'($urandom_range(0, 9));
				w.char_code = 8'($urandom_range(0, 255));
				if (pick < 5)
					w.cell_index = 11'(int'(cur_row_m) * COLS + int'($urandom_range(0, COLS - 1)));
				else if (pick < 9)
					w.cell_index = 11'($urandom_range(0, CELLS - 1));
				else
					w.cell_index = 11'($urandom_range(CELLS, 2047));
				send_word(w, 1'b0, '0);
			end
		end else if (kind < 90) begin
			n = int'($urandom_range(1, 12));
			w.char_code = NEWLINE_CHAR;
			repeat (n) send_word(w, 1'b0, '0);
		end else if (kind < 93) begin
			w.cmd = CMD_CLEAR;
			send_word(w, 1'b0, '0);
		end else begin
			w.cmd = 2'($urandom_range(0, 3));
			send_word(w, 1'b0, '0);
		end
	endtask

	task automatic wait_drained();
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	// Attribute write; only called with nothing in flight.
	task automatic write_attribute(input logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		attr_m = v;
	endtask

	// ---------------------------------------------------------------
	// Result side: check every accepted word, then pick next ready.
	// A hold request parks ready low for HOLD_CYCLES so the queue fills
	// and items.ready drops while the sender keeps offering.
	// ---------------------------------------------------------------
	initial begin
		tcw_result_t want;
		int hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (pending_reports.size() == 0) begin
					fault_count++;
					$display("%0t: result word %h with nothing expected", $time, result_ch.data);
				end else begin
					want = pending_reports.pop_front();
					if (result_ch.data.cell_value !== want.cell_value) begin
						fault_count++;
						$display("%0t: cell_value expected %h actual %h", $time,
							want.cell_value, result_ch.data.cell_value);
					end
					if (result_ch.data.cursor_row !== want.cursor_row) begin
						fault_count++;
						$display("%0t: cursor_row expected %0d actual %0d", $time,
							want.cursor_row, result_ch.data.cursor_row);
					end
					if (result_ch.data.cursor_column !== want.cursor_column) begin
						fault_count++;
						$display("%0t: cursor_column expected %0d actual %0d", $time,
							want.cursor_column, result_ch.data.cursor_column);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------
	// Watchdog
	// ---------------------------------------------------------------
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("text_console_writer_unit: mismatch");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence: reset, directed rows, then four idling phases with
	// an attribute change (0x00, 0xFF, random) in front of each later one.
	// ---------------------------------------------------------------
	initial begin
		int idle_plan [4];
		int stall_plan [4];
		int phase_end;
		tcw_item_t w;
		idle_plan  = '{0, 60, 0, 38};
		stall_plan = '{0, 0, 60, 38};

		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.data   <= '0;
		arst_n        <= 1'b0;

		attr_m    = RESET_ATTRIBUTE;
		cur_row_m = '0;
		cur_col_m = '0;
		blank_screen();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		fault_count    = 0;
		words_sent     = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// The power-up clearing pass keeps items.ready low; send_word waits it out.
		foreach (boot_rows[i]) begin
			w.cmd        = boot_rows[i].cmd;
			w.char_code  = boot_rows[i].ch;
			w.cell_index = boot_rows[i].idx;
			send_word(w, boot_rows[i].typed, boot_rows[i].want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			if (phase > 0) begin
				item_ch.valid <= 1'b0;
				wait_drained();
				case (phase)
					1: write_attribute(8'h00);
					2: write_attribute(8'hFF);
					default: write_attribute(8'($urandom_range(1, 254)));
				endcase
			end
			send_idle_pct  = idle_plan[phase];
			recv_stall_pct = stall_plan[phase];
			// long receiver hold while the sender runs flat out
			if (phase == 0)
				hold_request = 1'b1;
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) send_console_burst();
		end

		item_ch.valid <= 1'b0;
		recv_stall_pct = 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("text_console_writer_unit: match");
		else
			$display("text_console_writer_unit: mismatch");
		$finish;
	end

endmodule
